// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the shortest path engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SSP_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SSP_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ssp_pkg.sv
// Package with the constants, types and state codes of the shortest path engine.
package ssp_pkg;

    localparam int NODE_W     = 10;
    localparam int NODE_COUNT = 1 << NODE_W;
    localparam int EDGE_COUNT = 4096;
    localparam int EDGE_AW    = $clog2(EDGE_COUNT);
    localparam int LINK_W     = EDGE_AW + 1;
    localparam int WEIGHT_W   = 31;
    localparam int DIST_W     = 48;
    localparam int HEAP_DEPTH = EDGE_COUNT + 1;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);

    localparam logic [LINK_W-1:0] LIST_EMPTY = LINK_W'(EDGE_COUNT);
    localparam logic [DIST_W:0]   DIST_INF   = (DIST_W + 1)'(1) << DIST_W;
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [NODE_W-1:0]   end_node;
        logic [LINK_W-1:0]   link;
        logic [WEIGHT_W-1:0] cost;
    } edge_t;

    typedef struct packed {
        logic            settled;
        logic [DIST_W:0] path_len;
    } dist_t;

    typedef struct packed {
        logic [DIST_W-1:0] key;
        logic [NODE_W-1:0] vtx;
    } heap_ent_t;

    typedef struct packed {
        logic      push;
        logic      pop;
        logic      clear;
        heap_ent_t ent;
    } heap_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              empty;
        logic [NODE_W-1:0] top;
    } heap_stat_t;

    typedef enum logic [3:0] {
        H_IDLE,
        H_P_TOP,
        H_P_LAST,
        H_P_C1,
        H_P_C2,
        H_P_C3,
        H_P_CMP,
        H_U_CHK,
        H_U_CMP,
        H_DONE
    } heap_state_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SEED,
        S_POP,
        S_POPW,
        S_ULOOK,
        S_USET,
        S_HEAD,
        S_EDGE,
        S_EREAD,
        S_RELAX,
        S_PUSHW,
        S_FIN,
        S_RES,
        S_OUT
    } top_state_t;

endpackage

// File: rtl/ssp_if.sv
// Handshake interfaces for the request and response channels.
interface ssp_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [ssp_pkg::NODE_W-1:0]    from_node;
    logic [ssp_pkg::NODE_W-1:0]    to_node;
    logic [ssp_pkg::WEIGHT_W-1:0]  weight;
    logic [ssp_pkg::NODE_W-1:0]    start_node;
    logic [ssp_pkg::NODE_W-1:0]    target;

    modport source (output valid, kind, from_node, to_node, weight, start_node, target,
                    input ready);
    modport sink (input valid, kind, from_node, to_node, weight, start_node, target,
                  output ready);
endinterface

interface ssp_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ssp_pkg::DIST_W-1:0]  distance;
    logic                        reachable;
    logic                        edges_dropped;

    modport source (output valid, distance, reachable, edges_dropped, input ready);
    modport sink (input valid, distance, reachable, edges_dropped, output ready);
endinterface

// File: rtl/ssp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ssp_heap.sv
// Binary min-heap sequencer over a single RAM, one read or write step per cycle.
`include "assert_macros.svh"

module ssp_heap (
    input  logic                clk,
    input  logic                rst_n,
    input  ssp_pkg::heap_cmd_t  cmd,
    output ssp_pkg::heap_stat_t stat
);
    import ssp_pkg::*;

    heap_state_t state_reg, state_next;
    logic [HEAP_AW-1:0] fill_reg, fill_next;
    logic [HEAP_AW-1:0] pos_reg, pos_next;
    logic [HEAP_AW-1:0] cidx_reg, cidx_next;
    heap_ent_t          item_reg, item_next;
    heap_ent_t          child_reg, child_next;
    logic [NODE_W-1:0]  top_reg, top_next;

    logic               we;
    logic [HEAP_AW-1:0] waddr;
    heap_ent_t          wdata;
    logic [HEAP_AW-1:0] raddr;
    heap_ent_t          rdata;
    logic               done;

    logic [HEAP_AW:0]   c_wide;
    logic [HEAP_AW:0]   c1_wide;
    logic [HEAP_AW:0]   fill_wide;
    logic [HEAP_AW-1:0] up;

    ssp_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(HEAP_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign c_wide    = {pos_reg, 1'b1};
    assign c1_wide   = c_wide + (HEAP_AW + 1)'(1);
    assign fill_wide = {1'b0, fill_reg};
    assign up        = (pos_reg - HEAP_AW'(1)) >> 1;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        cidx_next  = cidx_reg;
        item_next  = item_reg;
        child_next = child_reg;
        top_next   = top_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = item_reg;
        raddr      = '0;
        done       = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.clear)
                begin
                    fill_next = '0;
                end
                else if (cmd.push)
                begin
                    if (fill_reg >= HEAP_AW'(HEAP_DEPTH))
                    begin
                        state_next = H_DONE;
                    end
                    else
                    begin
                        pos_next   = fill_reg;
                        fill_next  = fill_reg + HEAP_AW'(1);
                        item_next  = cmd.ent;
                        state_next = H_U_CHK;
                    end
                end
                else if (cmd.pop)
                begin
                    fill_next  = fill_reg - HEAP_AW'(1);
                    raddr      = '0;
                    state_next = H_P_TOP;
                end
            end
            H_P_TOP:
            begin
                top_next = rdata.vtx;
                if (fill_reg == '0)
                begin
                    state_next = H_DONE;
                end
                else
                begin
                    raddr      = fill_reg;
                    state_next = H_P_LAST;
                end
            end
            H_P_LAST:
            begin
                item_next  = rdata;
                pos_next   = '0;
                state_next = H_P_C1;
            end
            H_P_C1:
            begin
                if (c_wide >= fill_wide)
                begin
                    we         = 1'b1;
                    done       = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = c_wide[HEAP_AW-1:0];
                    state_next = H_P_C2;
                end
            end
            H_P_C2:
            begin
                child_next = rdata;
                cidx_next  = c_wide[HEAP_AW-1:0];
                if (c1_wide < fill_wide)
                begin
                    raddr      = c1_wide[HEAP_AW-1:0];
                    state_next = H_P_C3;
                end
                else
                begin
                    state_next = H_P_CMP;
                end
            end
            H_P_C3:
            begin
                if (rdata.key < child_reg.key)
                begin
                    child_next = rdata;
                    cidx_next  = cidx_reg + HEAP_AW'(1);
                end
                state_next = H_P_CMP;
            end
            H_P_CMP:
            begin
                we = 1'b1;
                if (child_reg.key >= item_reg.key)
                begin
                    done       = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    wdata      = child_reg;
                    pos_next   = cidx_reg;
                    state_next = H_P_C1;
                end
            end
            H_U_CHK:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    done       = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    raddr      = up;
                    cidx_next  = up;
                    state_next = H_U_CMP;
                end
            end
            H_U_CMP:
            begin
                we = 1'b1;
                if (rdata.key <= item_reg.key)
                begin
                    done       = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    wdata      = rdata;
                    pos_next   = cidx_reg;
                    state_next = H_U_CHK;
                end
            end
            H_DONE:
            begin
                done       = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        cidx_reg  <= cidx_next;
        item_reg  <= item_next;
        child_reg <= child_next;
        top_reg   <= top_next;
    end

    assign stat.busy  = (state_reg != H_IDLE);
    assign stat.done  = done;
    assign stat.empty = (fill_reg == '0);
    assign stat.top   = top_reg;

    `SSP_ASSERT_IMP(a_cmd_when_idle, cmd.push || cmd.pop || cmd.clear, state_reg == H_IDLE)
    `SSP_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= HEAP_AW'(HEAP_DEPTH))
    `SSP_ASSERT_IMP(a_pop_nonempty, cmd.pop, fill_reg != '0)

endmodule

// File: rtl/single_source_shortest_path.sv
// Top level of the shortest path engine: edge store, distance table and search sequencer.
//
// Request channel req carries one word per command: kind 0 clears the graph, kind 1 adds
// the directed edge from_node -> to_node with the given weight, kind 2 runs a search from
// start_node and reports the distance to target. Response channel rsp returns one word per
// search: distance (saturated at 2^48-1, 0 when unreachable), reachable, edges_dropped.
// Adds stream at one word per cycle; the adjacency head of the start node is read and
// written back in the following cycle, with forwarding when two adds in a row share a
// start node. A clear sweeps the 1024 list heads, one per cycle, holding req.ready low
// for the sweep. A search first sweeps the distance table, then runs Dijkstra: each heap
// pop reads the top and the last entry and walks down level by level, each edge scan
// reads one edge and the distance of its end node, and each heap push climbs level by
// level; the single heap RAM port serialises these steps. req.ready is low for the whole
// search. After reset all 1024 list heads are cleared before the first word is taken.
// The result sits in an output register; while rsp is stalled, adds and clears are still
// taken, and a later search holds its result until the slot frees.
`include "assert_macros.svh"

module single_source_shortest_path (
    input  logic       clk,
    input  logic       rst_n,
    ssp_req_if.sink    req,
    ssp_rsp_if.source  rsp
);
    import ssp_pkg::*;

    top_state_t state_reg, state_next;
    logic [NODE_W-1:0]  ctr_reg, ctr_next;
    logic [LINK_W-1:0]  fill_reg, fill_next;
    logic               dropped_reg, dropped_next;

    // Add pipeline: the add is held in the stage registers, which write the edge and the new list head.
    logic               stg_valid_reg, stg_valid_next;
    logic [NODE_W-1:0]  stg_from_reg, stg_from_next;
    logic [NODE_W-1:0]  stg_to_reg, stg_to_next;
    logic [WEIGHT_W-1:0] stg_weight_reg, stg_weight_next;
    logic [EDGE_AW-1:0] stg_idx_reg, stg_idx_next;
    logic               fwd_hit_reg, fwd_hit_next;
    logic [EDGE_AW-1:0] fwd_idx_reg, fwd_idx_next;

    // Search registers.
    logic [NODE_W-1:0]  src_reg, src_next;
    logic [NODE_W-1:0]  tgt_reg, tgt_next;
    logic [NODE_W-1:0]  u_reg, u_next;
    logic [DIST_W-1:0]  du_reg, du_next;
    logic [LINK_W-1:0]  link_reg, link_next;
    logic [NODE_W-1:0]  v_reg, v_next;
    logic [DIST_W-1:0]  sum_reg, sum_next;
    logic [LINK_W-1:0]  nlink_reg, nlink_next;
    logic [DIST_W-1:0]  res_dist_reg, res_dist_next;
    logic               res_reach_reg, res_reach_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic               out_reach_reg, out_reach_next;
    logic               out_drop_reg, out_drop_next;

    logic               accept;
    logic [LINK_W-1:0]  stg_link;
    logic [DIST_W:0]    sum_wide;

    // Memory ports.
    logic               head_we;
    logic [NODE_W-1:0]  head_waddr;
    logic [LINK_W-1:0]  head_wdata;
    logic [NODE_W-1:0]  head_raddr;
    logic [LINK_W-1:0]  head_rdata;

    logic               edge_we;
    edge_t              edge_wdata;
    logic [EDGE_AW-1:0] edge_raddr;
    edge_t              edge_rdata;

    logic               dist_we;
    logic [NODE_W-1:0]  dist_waddr;
    dist_t              dist_wdata;
    logic [NODE_W-1:0]  dist_raddr;
    dist_t              dist_rdata;

    heap_cmd_t          heap_cmd;
    heap_stat_t         heap_stat;

    ssp_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    ssp_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGE_COUNT)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (stg_idx_reg),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    ssp_ram #(.WIDTH($bits(dist_t)), .DEPTH(NODE_COUNT)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    ssp_heap u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (heap_cmd),
        .stat  (heap_stat)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // The list head read in the accept cycle misses a head written in that same cycle.
    assign stg_link  = fwd_hit_reg ? {1'b0, fwd_idx_reg} : head_rdata;
    assign sum_wide  = {1'b0, du_reg} + (DIST_W + 1)'(edge_rdata.cost);

    assign edge_we    = stg_valid_reg;
    assign edge_wdata = '{end_node: stg_to_reg, link: stg_link, cost: stg_weight_reg};
    assign edge_raddr = link_reg[EDGE_AW-1:0];
    assign head_raddr = (state_reg == S_IDLE) ? req.from_node : u_reg;

    always_comb
    begin
        state_next      = state_reg;
        ctr_next        = ctr_reg;
        fill_next       = fill_reg;
        dropped_next    = dropped_reg;
        stg_valid_next  = 1'b0;
        stg_from_next   = stg_from_reg;
        stg_to_next     = stg_to_reg;
        stg_weight_next = stg_weight_reg;
        stg_idx_next    = stg_idx_reg;
        fwd_hit_next    = 1'b0;
        fwd_idx_next    = fwd_idx_reg;
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        u_next          = u_reg;
        du_next         = du_reg;
        link_next       = link_reg;
        v_next          = v_reg;
        sum_next        = sum_reg;
        nlink_next      = nlink_reg;
        res_dist_next   = res_dist_reg;
        res_reach_next  = res_reach_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_dist_next   = out_dist_reg;
        out_reach_next  = out_reach_reg;
        out_drop_next   = out_drop_reg;

        // The clearing sweep owns the head port; a pending add is void under a clear.
        head_we    = stg_valid_reg;
        head_waddr = stg_from_reg;
        head_wdata = {1'b0, stg_idx_reg};

        dist_we    = 1'b0;
        dist_waddr = u_reg;
        dist_wdata = dist_rdata;
        dist_raddr = u_reg;
        heap_cmd   = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = ctr_reg;
                head_wdata = LIST_EMPTY;
                ctr_next   = ctr_reg + NODE_W'(1);
                if (ctr_reg == {NODE_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.kind)
                        KIND_CLEAR:
                        begin
                            fill_next    = '0;
                            dropped_next = 1'b0;
                            ctr_next     = '0;
                            state_next   = S_CLEAR;
                        end
                        KIND_ADD:
                        begin
                            if (fill_reg == LINK_W'(EDGE_COUNT))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                stg_valid_next  = 1'b1;
                                stg_from_next   = req.from_node;
                                stg_to_next     = req.to_node;
                                stg_weight_next = req.weight;
                                stg_idx_next    = fill_reg[EDGE_AW-1:0];
                                fill_next       = fill_reg + LINK_W'(1);
                                fwd_hit_next    = stg_valid_reg &&
                                                  (stg_from_reg == req.from_node);
                                fwd_idx_next    = stg_idx_reg;
                            end
                        end
                        KIND_QUERY:
                        begin
                            src_next   = req.start_node;
                            tgt_next   = req.target;
                            ctr_next   = '0;
                            state_next = S_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                dist_we    = 1'b1;
                dist_waddr = ctr_reg;
                dist_wdata = '{settled: 1'b0,
                               path_len: (ctr_reg == src_reg) ? '0 : DIST_INF};
                heap_cmd.clear = (ctr_reg == '0);
                ctr_next   = ctr_reg + NODE_W'(1);
                if (ctr_reg == {NODE_W{1'b1}})
                begin
                    heap_cmd.push = 1'b1;
                    heap_cmd.ent  = '{key: '0, vtx: src_reg};
                    state_next    = S_SEED;
                end
            end
            S_SEED:
            begin
                if (heap_stat.done)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (heap_stat.empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    heap_cmd.pop = 1'b1;
                    state_next   = S_POPW;
                end
            end
            S_POPW:
            begin
                if (heap_stat.done)
                begin
                    state_next = S_ULOOK;
                end
            end
            S_ULOOK:
            begin
                dist_raddr = heap_stat.top;
                u_next     = heap_stat.top;
                state_next = S_USET;
            end
            S_USET:
            begin
                // Lazy deletion: a node popped again after it settled is skipped.
                if (dist_rdata.settled)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dist_we    = 1'b1;
                    dist_wdata = '{settled: 1'b1, path_len: dist_rdata.path_len};
                    du_next    = dist_rdata.path_len[DIST_W-1:0];
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                link_next  = head_rdata;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (link_reg >= fill_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_EREAD;
                end
            end
            S_EREAD:
            begin
                sum_next   = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
                v_next     = edge_rdata.end_node;
                nlink_next = edge_rdata.link;
                dist_raddr = edge_rdata.end_node;
                state_next = S_RELAX;
            end
            S_RELAX:
            begin
                if (dist_rdata.path_len > {1'b0, sum_reg})
                begin
                    dist_we       = 1'b1;
                    dist_waddr    = v_reg;
                    dist_wdata    = '{settled: dist_rdata.settled,
                                      path_len: {1'b0, sum_reg}};
                    heap_cmd.push = 1'b1;
                    heap_cmd.ent  = '{key: sum_reg, vtx: v_reg};
                    state_next    = S_PUSHW;
                end
                else
                begin
                    link_next  = nlink_reg;
                    state_next = S_EDGE;
                end
            end
            S_PUSHW:
            begin
                if (heap_stat.done)
                begin
                    link_next  = nlink_reg;
                    state_next = S_EDGE;
                end
            end
            S_FIN:
            begin
                dist_raddr = tgt_reg;
                state_next = S_RES;
            end
            S_RES:
            begin
                res_reach_next = !dist_rdata.path_len[DIST_W];
                res_dist_next  = dist_rdata.path_len[DIST_W] ? '0
                                                             : dist_rdata.path_len[DIST_W-1:0];
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = res_dist_reg;
                    out_reach_next = res_reach_reg;
                    out_drop_next  = dropped_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ctr_reg       <= '0;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            stg_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            stg_valid_reg <= stg_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_from_reg   <= stg_from_next;
        stg_to_reg     <= stg_to_next;
        stg_weight_reg <= stg_weight_next;
        stg_idx_reg    <= stg_idx_next;
        fwd_idx_reg    <= fwd_idx_next;
        src_reg        <= src_next;
        tgt_reg        <= tgt_next;
        u_reg          <= u_next;
        du_reg         <= du_next;
        link_reg       <= link_next;
        v_reg          <= v_next;
        sum_reg        <= sum_next;
        nlink_reg      <= nlink_next;
        res_dist_reg   <= res_dist_next;
        res_reach_reg  <= res_reach_next;
        out_dist_reg   <= out_dist_next;
        out_reach_reg  <= out_reach_next;
        out_drop_reg   <= out_drop_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.distance      = out_dist_reg;
    assign rsp.reachable     = out_reach_reg;
    assign rsp.edges_dropped = out_drop_reg;

    `SSP_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= LINK_W'(EDGE_COUNT))
    `SSP_ASSERT_NXT(a_drop_on_full, accept && (req.kind == KIND_ADD) && (fill_reg == LINK_W'(EDGE_COUNT)), dropped_reg)
    `SSP_ASSERT_IMP(a_fwd_needs_add, fwd_hit_reg, stg_valid_reg)

endmodule
